/* rtl/tsp_pkg.sv */
// Shared types and constants for the tile map scroll planner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int WIN_W_TILES = 33;
  localparam int WIN_H_TILES = 25;
  localparam int BLOCK_TILES = 32;
  localparam int BLOCK_BYTES = BLOCK_TILES * BLOCK_TILES * 2;
  localparam int ROW_SHIFT   = $clog2(BLOCK_TILES * 2);
  localparam int MAP_MAX     = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_COPY  = 2'd1;
  localparam logic [1:0] KIND_XFER  = 2'd2;
  localparam logic [1:0] KIND_FINE  = 2'd3;

  localparam logic REG_MAP_W = 1'b0;
  localparam logic REG_MAP_H = 1'b1;

  typedef struct packed {
    logic       changed;
    logic       has_copy;
    logic [3:0] fx;
    logic [3:0] fy;
    logic [5:0] sx;
    logic [5:0] sy;
    logic [6:0] dx;
    logic [6:0] dy;
    logic [5:0] w;
    logic [4:0] h;
  } job_t;

endpackage

/* rtl/tilemap_scroll_block_copy_planner.sv */
// Top level of the tile map scroll planner: front end, job queue, back end.
// Depends on tsp_pkg, tsp_front, tsp_queue and tsp_back.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_ready carries one scroll position (pos_x, pos_y).
//   Output channel out_valid/out_ready carries result items, one per cycle:
//   while not stalled: on a coarse tile change a clear, up to four copy
//   rectangles and a transfer request, then always a fine scroll item with last set.
//   wr_en/wr_index/wr_data set map width (index 0) and height (index 1);
//   write only while no item is in flight.
//   With the queue empty, an accepted item is first written into the queue,
//   and its first result is registered into the output register from there.
//   The back end sequencer steps through the results of the job at the queue
//   head, one result item per cycle while the receiver takes them. The front
//   end classifies in the accept cycle; the queue holds two jobs, the one in
//   progress included, so one more item is taken while the back end works.
//   Reset (rst, synchronous): map size 32 x 24 tiles, stored coarse position
//   0,0, queue and output register empty.
//   Receiver stall: the output register holds its item, the back end waits,
//   and in_ready falls once the queue is full.
module tilemap_scroll_block_copy_planner
  import tsp_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [6:0]        wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic signed [6:0] dest_x,
  output logic signed [5:0] dest_y,
  output logic [5:0]        rect_w,
  output logic [4:0]        rect_h,
  output logic [12:0]       src_offset,
  output logic [4:0]        src_x,
  output logic [4:0]        src_y,
  output logic [6:0]        src_w,
  output logic [6:0]        src_h,
  output logic              last
);

  job_t       f_job, q_job;
  logic       q_full, q_valid, q_pop, accept;
  logic [6:0] map_w, map_h;
  logic [6:0] dx_bits;
  logic [5:0] dy_bits;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  tsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .accept   (accept),
    .job      (f_job),
    .map_w    (map_w),
    .map_h    (map_h)
  );

  tsp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .wdata    (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_valid),
    .rdata    (q_job)
  );

  tsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .map_w      (map_w),
    .map_h      (map_h),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .dest_x     (dx_bits),
    .dest_y     (dy_bits),
    .rect_w     (rect_w),
    .rect_h     (rect_h),
    .src_offset (src_offset),
    .src_x      (src_x),
    .src_y      (src_y),
    .src_w      (src_w),
    .src_h      (src_h),
    .last       (last)
  );

  assign dest_x = $signed(dx_bits);
  assign dest_y = $signed(dy_bits);

endmodule

/* rtl/tsp_front.sv */
// Front end: map size registers, coarse/fine split, change detect and clipping.
// Depends on tsp_pkg; produces one job_t per accepted item.
`timescale 1ns / 1ps

module tsp_front
  import tsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [6:0]        wr_data,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic              accept,
  output job_t              job,
  output logic [6:0]        map_w,
  output logic [6:0]        map_h
);

  logic [6:0] map_w_reg;
  logic [6:0] map_h_reg;
  logic [6:0] last_cx;
  logic [6:0] last_cy;

  logic              fix_x, fix_y;
  logic [6:0]        cx, cy;
  logic [5:0]        sx, sy;
  logic [6:0]        dx, dy;
  logic signed [7:0] w0, h0, wlim, hlim, wclip, hclip;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_w_reg <= 7'd32;
      map_h_reg <= 7'd24;
      last_cx   <= '0;
      last_cy   <= '0;
    end else begin
      if (wr_en && wr_index == REG_MAP_W) begin
        map_w_reg <= wr_data;
      end else if (wr_en && wr_index == REG_MAP_H) begin
        map_h_reg <= wr_data;
      end
      if (accept) begin
        last_cx <= cx;
        last_cy <= cy;
      end
    end
  end

  assign map_w = (map_w_reg > 7'(MAP_MAX)) ? 7'(MAP_MAX) : map_w_reg;
  assign map_h = (map_h_reg > 7'(MAP_MAX)) ? 7'(MAP_MAX) : map_h_reg;

  // truncate toward zero: negative values with a fraction round up by one
  assign fix_x = pos_x[9] & (pos_x[2:0] != 3'd0);
  assign fix_y = pos_y[9] & (pos_y[2:0] != 3'd0);
  assign cx    = pos_x[9:3] + {6'd0, fix_x};
  assign cy    = pos_y[9:3] + {6'd0, fix_y};

  assign sx = cx[6] ? 6'd0 : cx[5:0];
  assign sy = cy[6] ? 6'd0 : cy[5:0];
  assign dx = cx[6] ? (7'd0 - cx) : 7'd0;
  assign dy = cy[6] ? (7'd0 - cy) : 7'd0;

  assign w0    = $signed(8'(WIN_W_TILES)) - $signed({1'b0, dx});
  assign h0    = $signed(8'(WIN_H_TILES)) - $signed({1'b0, dy});
  assign wlim  = $signed({1'b0, map_w}) - $signed({2'b0, sx});
  assign hlim  = $signed({1'b0, map_h}) - $signed({2'b0, sy});
  assign wclip = (wlim < w0) ? wlim : w0;
  assign hclip = (hlim < h0) ? hlim : h0;

  always_comb begin
    job.changed  = (cx != last_cx) || (cy != last_cy);
    job.has_copy = (wclip > 8'sd0) && (hclip > 8'sd0);
    job.fx       = {fix_x, pos_x[2:0]};
    job.fy       = {fix_y, pos_y[2:0]};
    job.sx       = sx;
    job.sy       = sy;
    job.dx       = dx;
    job.dy       = dy;
    job.w        = wclip[5:0];
    job.h        = hclip[4:0];
  end

endmodule

/* rtl/tsp_queue.sv */
// Short job queue between front and back ends.
// Depends on tsp_pkg for job_t.
`timescale 1ns / 1ps

module tsp_queue
  import tsp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = entries[rd_ptr];

endmodule

/* rtl/tsp_back.sv */
// Back end: sequences clear, copy pieces, transfer and fine scroll results.
// Depends on tsp_pkg; reads jobs from tsp_queue and drives the output register.
`timescale 1ns / 1ps

module tsp_back
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  input  logic [6:0]  map_w,
  input  logic [6:0]  map_h,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [6:0]  dest_x,
  output logic [5:0]  dest_y,
  output logic [5:0]  rect_w,
  output logic [4:0]  rect_h,
  output logic [12:0] src_offset,
  output logic [4:0]  src_x,
  output logic [4:0]  src_y,
  output logic [6:0]  src_w,
  output logic [6:0]  src_h,
  output logic        last
);

  localparam logic [1:0] ST_HEAD = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_XFER = 2'd2;
  localparam logic [1:0] ST_FINE = 2'd3;

  logic [1:0] state, state_next;
  logic       row, col, row_next, col_next;
  logic       load, emit;

  logic [1:0]  e_kind;
  logic [6:0]  e_dx;
  logic [5:0]  e_dy;
  logic [5:0]  e_w;
  logic [4:0]  e_h;
  logic [12:0] e_off;
  logic [4:0]  e_sx, e_sy;
  logic [6:0]  e_sw, e_sh;
  logic        e_last;

  logic [5:0]  room_x, room_y, cw_a, cw_b;
  logic [4:0]  ch_a, ch_b;
  logic        col_b, row_b, hs, vs, bx, by;
  logic [6:0]  ddx, ddy, bw, bh;
  logic [12:0] off;

  // piece geometry: at most one block edge in each direction
  assign room_x = 6'(BLOCK_TILES) - {1'b0, q_job.sx[4:0]};
  assign room_y = 6'(BLOCK_TILES) - {1'b0, q_job.sy[4:0]};
  assign cw_a   = (q_job.w <= room_x) ? q_job.w : room_x;
  assign ch_a   = ({1'b0, q_job.h} <= room_y) ? q_job.h : room_y[4:0];
  assign cw_b   = q_job.w - cw_a;
  assign ch_b   = q_job.h - ch_a;
  assign col_b  = (q_job.w > cw_a);
  assign row_b  = (q_job.h > ch_a);

  assign bx  = col ? 1'b1 : q_job.sx[5];
  assign by  = row ? 1'b1 : q_job.sy[5];
  assign ddx = q_job.dx + (col ? {1'b0, cw_a} : 7'd0);
  assign ddy = q_job.dy + (row ? {2'b0, ch_a} : 7'd0);
  assign hs  = (map_w > 7'(BLOCK_TILES));
  assign vs  = (map_h > 7'(BLOCK_TILES));
  assign bw  = hs ? (bx ? map_w - 7'(BLOCK_TILES) : 7'(BLOCK_TILES)) : map_w;
  assign bh  = vs ? (by ? map_h - 7'(BLOCK_TILES) : 7'(BLOCK_TILES)) : map_h;

  always_comb begin
    off = '0;
    if (hs && vs) begin
      if (!by) begin
        off = bx ? 13'(BLOCK_BYTES) : 13'd0;
      end else begin
        off = (13'(map_w) << ROW_SHIFT)
            + (bx ? (13'(map_h - 7'(BLOCK_TILES)) << ROW_SHIFT) : 13'd0);
      end
    end else if (hs) begin
      off = bx ? (13'(map_h) << ROW_SHIFT) : 13'd0;
    end else if (vs) begin
      off = by ? (13'(map_w) << ROW_SHIFT) : 13'd0;
    end
  end

  always_comb begin
    e_kind     = KIND_FINE;
    e_dx       = {{3{q_job.fx[3]}}, q_job.fx};
    e_dy       = {{2{q_job.fy[3]}}, q_job.fy};
    e_w        = '0;
    e_h        = '0;
    e_off      = '0;
    e_sx       = '0;
    e_sy       = '0;
    e_sw       = '0;
    e_sh       = '0;
    e_last     = 1'b1;
    q_pop      = 1'b0;
    state_next = state;
    row_next   = row;
    col_next   = col;
    unique case (state)
      ST_HEAD: begin
        if (q_job.changed) begin
          e_kind     = KIND_CLEAR;
          e_dx       = '0;
          e_dy       = '0;
          e_w        = 6'(WIN_W_TILES);
          e_h        = 5'(WIN_H_TILES);
          e_last     = 1'b0;
          row_next   = 1'b0;
          col_next   = 1'b0;
          state_next = q_job.has_copy ? ST_COPY : ST_XFER;
        end else begin
          q_pop = q_valid;
        end
      end
      ST_COPY: begin
        e_kind = KIND_COPY;
        e_dx   = ddx;
        e_dy   = ddy[5:0];
        e_w    = col ? cw_b : cw_a;
        e_h    = row ? ch_b : ch_a;
        e_off  = off;
        e_sx   = col ? 5'd0 : q_job.sx[4:0];
        e_sy   = row ? 5'd0 : q_job.sy[4:0];
        e_sw   = bw;
        e_sh   = bh;
        e_last = 1'b0;
        if (!col && col_b) begin
          col_next = 1'b1;
        end else if (!row && row_b) begin
          row_next = 1'b1;
          col_next = 1'b0;
        end else begin
          state_next = ST_XFER;
        end
      end
      ST_XFER: begin
        e_kind     = KIND_XFER;
        e_dx       = '0;
        e_dy       = '0;
        e_last     = 1'b0;
        state_next = ST_FINE;
      end
      ST_FINE: begin
        q_pop      = 1'b1;
        state_next = ST_HEAD;
      end
      default: begin
        state_next = ST_HEAD;
      end
    endcase
    if (!(load && emit)) begin
      q_pop      = 1'b0;
      state_next = state;
      row_next   = row;
      col_next   = col;
    end
  end

  assign load = !out_valid || out_ready;
  assign emit = (state != ST_HEAD) || q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HEAD;
      row       <= 1'b0;
      col       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      kind       <= e_kind;
      dest_x     <= e_dx;
      dest_y     <= e_dy;
      rect_w     <= e_w;
      rect_h     <= e_h;
      src_offset <= e_off;
      src_x      <= e_sx;
      src_y      <= e_sy;
      src_w      <= e_sw;
      src_h      <= e_sh;
      last       <= e_last;
    end
  end

  a_last_on_fine: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_FINE)))
    else $error("last flag does not match fine scroll result");

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (state != ST_HEAD) |-> q_valid)
    else $error("sequencer busy with no job at queue head");

  a_copy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_COPY) |-> (rect_w != 6'd0 && rect_h != 5'd0))
    else $error("empty copy rectangle emitted");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (out_valid && last))
    else $error("job retired without a final result");

endmodule
